// ===== rtl/core/rqsg_pkg.sv =====
// shared types, constants and helpers of the rolling quantile signal gate
`timescale 1ns / 1ps
`default_nettype none

package rqsg_pkg;

	// ring geometry
	localparam int unsigned WINDOW = 256;
	localparam int unsigned ADDR_W = $clog2(WINDOW);
	localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

	// field widths
	localparam int unsigned PROB_W  = 16;
	localparam int unsigned RANK_W  = 8;
	localparam int unsigned CD_W    = 8;
	localparam int unsigned WARM_W  = 16;
	localparam int unsigned DEC_W   = 2;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned PADDR_W = 5;

	// register reset values
	localparam logic [RANK_W-1:0] RST_RANK_LONG  = 8'd178;
	localparam logic [RANK_W-1:0] RST_RANK_SHORT = 8'd76;
	localparam logic [PROB_W-1:0] RST_LONG_MIN   = 16'd33423;
	localparam logic [PROB_W-1:0] RST_SHORT_MAX  = 16'd32113;
	localparam logic [CD_W-1:0]   RST_COOLDOWN   = 8'd5;
	localparam logic [WARM_W-1:0] RST_WARMUP     = 16'd256;

	// 0.5 in Q0.16
	localparam logic [PROB_W-1:0] NEUTRAL_PROB = 16'd32768;

	typedef enum logic [DEC_W-1:0] {
		DEC_NEUTRAL = 2'd0,
		DEC_LONG    = 2'd1,
		DEC_SHORT   = 2'd2
	} dec_t;

	typedef enum logic [2:0] {
		REG_RANK_LONG  = 3'd0,
		REG_RANK_SHORT = 3'd1,
		REG_LONG_MIN   = 3'd2,
		REG_SHORT_MAX  = 3'd3,
		REG_COOLDOWN   = 3'd4,
		REG_WARMUP     = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	// rank limited to the last order statistic of the window
	function automatic logic [CNT_W-1:0] clamp_rank(input logic [RANK_W-1:0] rank);
		logic [31:0] r32;
		r32 = 32'(rank);
		if (r32 > 32'(WINDOW - 1)) begin
			return CNT_W'(WINDOW - 1);
		end else begin
			return CNT_W'(rank);
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rqsg_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rqsg_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rolling_quantile_signal_gate_unit.sv =====
// top level of the rolling quantile signal gate
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | in_valid / in_ready | probability[15:0]
//  out     | output    | out_valid/out_ready | decision[1:0], prob_out[15:0]
//  apb     | input     | psel/penable/pready | paddr[4:0], pwdata, prdata
//
// one item at a time: accept, ring scan over the whole window, drain, decide;
// during warm-up the scan and drain are skipped and the item goes straight to decide
// the scan rate is set by the single read port of the history ring, one entry a cycle
// in_ready is high only while idle; a finished result waits in the output register
// and the next item is accepted meanwhile, but its result waits until out_ready
// arst_n clears control state and configuration registers; ring contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module rolling_quantile_signal_gate_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input item channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [rqsg_pkg::PROB_W-1:0]    probability,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [rqsg_pkg::DEC_W-1:0]     decision,
	output logic      [rqsg_pkg::PROB_W-1:0]    prob_out,
	// configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rqsg_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [rqsg_pkg::DATA_W-1:0]    pwdata,
	output logic      [rqsg_pkg::DATA_W-1:0]    prdata,
	output logic                                pready
);

	// configuration registers
	logic [rqsg_pkg::RANK_W-1:0] rank_long_q;
	logic [rqsg_pkg::RANK_W-1:0] rank_short_q;
	logic [rqsg_pkg::PROB_W-1:0] long_min_q;
	logic [rqsg_pkg::PROB_W-1:0] short_max_q;
	logic [rqsg_pkg::CD_W-1:0]   cooldown_q;
	logic [rqsg_pkg::WARM_W-1:0] warmup_q;

	// running state
	rqsg_pkg::state_t            state_q, state_d;
	logic [rqsg_pkg::ADDR_W-1:0] write_ptr_q;
	logic [rqsg_pkg::WARM_W-1:0] sample_count_q;
	logic [rqsg_pkg::CD_W-1:0]   long_wait_q;
	logic [rqsg_pkg::CD_W-1:0]   short_wait_q;

	// per-item working registers
	logic [rqsg_pkg::PROB_W-1:0] sample_q;
	logic                        warm_q;
	logic [rqsg_pkg::CNT_W-1:0]  scan_cnt_q;
	logic                        rd_vld_s1;
	logic [rqsg_pkg::CNT_W-1:0]  n_le_q;
	logic [rqsg_pkg::CNT_W-1:0]  n_lt_q;

	// output register
	logic                        out_valid_q;
	rqsg_pkg::dec_t              decision_q;
	logic [rqsg_pkg::PROB_W-1:0] prob_out_q;

	// ring interface
	logic                        ram_re;
	logic [rqsg_pkg::PROB_W-1:0] ram_rdata;

	logic                        in_accept;
	logic                        cfg_write;
	logic                        load_out;
	logic [rqsg_pkg::WARM_W-1:0] warm_thr;
	logic [rqsg_pkg::WARM_W-1:0] count_next;
	logic [rqsg_pkg::CNT_W-1:0]  k_long;
	logic [rqsg_pkg::CNT_W-1:0]  k_short;
	logic                        fire_long;
	logic                        fire_short;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign in_accept = in_valid & in_ready;

	// warm-up threshold never below a full window
	assign warm_thr   = (warmup_q < rqsg_pkg::WARM_W'(rqsg_pkg::WINDOW)) ?
		rqsg_pkg::WARM_W'(rqsg_pkg::WINDOW) : warmup_q;
	assign count_next = (sample_count_q < warm_thr) ? sample_count_q + 1'b1 : sample_count_q;

	// rank tests on the finished counts
	assign k_long     = rqsg_pkg::clamp_rank(rank_long_q);
	assign k_short    = rqsg_pkg::clamp_rank(rank_short_q);
	assign fire_long  = warm_q && (long_wait_q == '0) && (sample_q >= long_min_q) &&
		(n_le_q > k_long);
	assign fire_short = warm_q && !fire_long && (short_wait_q == '0) &&
		(sample_q <= short_max_q) && (n_lt_q <= k_short);

	// history ring
	rqsg_ram #(
		.WIDTH (rqsg_pkg::PROB_W),
		.DEPTH (rqsg_pkg::WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (in_accept),
		.waddr (write_ptr_q),
		.wdata (probability),
		.re    (ram_re),
		.raddr (scan_cnt_q[rqsg_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ram_re   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			rqsg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// scan only once the window is full and warmed up
					state_d = (count_next >= warm_thr) ? rqsg_pkg::ST_SCAN : rqsg_pkg::ST_DONE;
				end
			end
			rqsg_pkg::ST_SCAN: begin
				ram_re = 1'b1;
				if (scan_cnt_q == rqsg_pkg::CNT_W'(rqsg_pkg::WINDOW - 1)) begin
					state_d = rqsg_pkg::ST_LAST;
				end
			end
			rqsg_pkg::ST_LAST: begin
				// last read data lands in the counters this cycle
				state_d = rqsg_pkg::ST_DONE;
			end
			rqsg_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = rqsg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rqsg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rqsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring pointer, warm-up count and cooldowns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_ptr_q    <= '0;
			sample_count_q <= '0;
			long_wait_q    <= '0;
			short_wait_q   <= '0;
			warm_q         <= 1'b0;
		end else if (in_accept) begin
			write_ptr_q    <= (write_ptr_q == rqsg_pkg::ADDR_W'(rqsg_pkg::WINDOW - 1)) ?
				'0 : write_ptr_q + 1'b1;
			sample_count_q <= count_next;
			warm_q         <= (count_next >= warm_thr);
			// cooldowns tick on every item, also during warm-up
			if (long_wait_q != '0) begin
				long_wait_q <= long_wait_q - 1'b1;
			end
			if (short_wait_q != '0) begin
				short_wait_q <= short_wait_q - 1'b1;
			end
		end else if (load_out) begin
			if (fire_long) begin
				long_wait_q <= cooldown_q;
			end else if (fire_short) begin
				short_wait_q <= cooldown_q;
			end
		end
	end

	// scan address and read-valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (in_accept) begin
				scan_cnt_q <= '0;
			end else if (ram_re) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end
	end

	// rank counters over the ring, compared with the held sample
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= probability;
			n_le_q   <= '0;
			n_lt_q   <= '0;
		end else if (rd_vld_s1) begin
			n_le_q <= n_le_q + rqsg_pkg::CNT_W'(ram_rdata <= sample_q);
			n_lt_q <= n_lt_q + rqsg_pkg::CNT_W'(ram_rdata < sample_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (fire_long) begin
				decision_q <= rqsg_pkg::DEC_LONG;
				prob_out_q <= sample_q;
			end else if (fire_short) begin
				decision_q <= rqsg_pkg::DEC_SHORT;
				prob_out_q <= sample_q;
			end else begin
				decision_q <= rqsg_pkg::DEC_NEUTRAL;
				prob_out_q <= rqsg_pkg::NEUTRAL_PROB;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign decision  = decision_q;
	assign prob_out  = prob_out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_long_q  <= rqsg_pkg::RST_RANK_LONG;
			rank_short_q <= rqsg_pkg::RST_RANK_SHORT;
			long_min_q   <= rqsg_pkg::RST_LONG_MIN;
			short_max_q  <= rqsg_pkg::RST_SHORT_MAX;
			cooldown_q   <= rqsg_pkg::RST_COOLDOWN;
			warmup_q     <= rqsg_pkg::RST_WARMUP;
		end else if (cfg_write) begin
			unique case (rqsg_pkg::reg_idx_t'(paddr[4:2]))
				rqsg_pkg::REG_RANK_LONG:  rank_long_q  <= pwdata[rqsg_pkg::RANK_W-1:0];
				rqsg_pkg::REG_RANK_SHORT: rank_short_q <= pwdata[rqsg_pkg::RANK_W-1:0];
				rqsg_pkg::REG_LONG_MIN:   long_min_q   <= pwdata[rqsg_pkg::PROB_W-1:0];
				rqsg_pkg::REG_SHORT_MAX:  short_max_q  <= pwdata[rqsg_pkg::PROB_W-1:0];
				rqsg_pkg::REG_COOLDOWN:   cooldown_q   <= pwdata[rqsg_pkg::CD_W-1:0];
				rqsg_pkg::REG_WARMUP:     warmup_q     <= pwdata[rqsg_pkg::WARM_W-1:0];
				default: begin
					// unknown register, write dropped
				end
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (rqsg_pkg::reg_idx_t'(paddr[4:2]))
			rqsg_pkg::REG_RANK_LONG:  prdata = rqsg_pkg::DATA_W'(rank_long_q);
			rqsg_pkg::REG_RANK_SHORT: prdata = rqsg_pkg::DATA_W'(rank_short_q);
			rqsg_pkg::REG_LONG_MIN:   prdata = rqsg_pkg::DATA_W'(long_min_q);
			rqsg_pkg::REG_SHORT_MAX:  prdata = rqsg_pkg::DATA_W'(short_max_q);
			rqsg_pkg::REG_COOLDOWN:   prdata = rqsg_pkg::DATA_W'(cooldown_q);
			rqsg_pkg::REG_WARMUP:     prdata = rqsg_pkg::DATA_W'(warmup_q);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/rqsg_checker.sv =====
// port-level checker of the rolling quantile signal gate and its bind
`timescale 1ns / 1ps
`default_nettype none

module rqsg_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [rqsg_pkg::DEC_W-1:0]     decision,
	input wire logic [rqsg_pkg::PROB_W-1:0]    prob_out
);

	// a waiting result holds still
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(decision) && $stable(prob_out))
		else $error("stalled result changed");

	// only the three decision codes appear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (decision == rqsg_pkg::DEC_NEUTRAL) || (decision == rqsg_pkg::DEC_LONG) ||
			(decision == rqsg_pkg::DEC_SHORT))
		else $error("undefined decision code");

	// neutral items carry one half
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (decision == rqsg_pkg::DEC_NEUTRAL) |-> prob_out == rqsg_pkg::NEUTRAL_PROB)
		else $error("neutral item without one half");

	// one item in flight: busy right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

endmodule

bind rolling_quantile_signal_gate_unit rqsg_checker u_rqsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.decision  (decision),
	.prob_out  (prob_out)
);

`default_nettype wire

// ===== tb/tb_rolling_quantile_signal_gate_unit.sv =====
// testbench of the rolling quantile signal gate: predicted decisions checked item by item
`timescale 1ns / 1ps

module tb_rolling_quantile_signal_gate_unit;

	// run limits
	localparam int unsigned CYCLE_LIMIT  = 3000000;
	localparam int unsigned HOLD_CYCLES  = 3000;
	localparam int unsigned SETTLE_CYCLES = 300;

	// register slots past the last one, writes there must be ignored
	localparam int unsigned REG_SPARE_LO = 6;
	localparam int unsigned REG_SPARE_HI = 7;

	// pacing of the two channels
	typedef enum int {
		PACE_FREE,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		rqsg_pkg::dec_t              decision;
		logic [rqsg_pkg::PROB_W-1:0] prob;
	} verdict_t;

	// mirror of the gate: ring, counters, cooldowns and registers
	class signal_gate_tracker;
		logic [rqsg_pkg::PROB_W-1:0] ring [rqsg_pkg::WINDOW];
		logic [rqsg_pkg::ADDR_W-1:0] wr_ptr;
		int unsigned                 seen;
		logic [rqsg_pkg::CD_W-1:0]   long_wait;
		logic [rqsg_pkg::CD_W-1:0]   short_wait;
		logic [rqsg_pkg::RANK_W-1:0] rank_long;
		logic [rqsg_pkg::RANK_W-1:0] rank_short;
		logic [rqsg_pkg::PROB_W-1:0] long_min;
		logic [rqsg_pkg::PROB_W-1:0] short_max;
		logic [rqsg_pkg::CD_W-1:0]   cooldown_len;
		logic [rqsg_pkg::WARM_W-1:0] warmup_len;
		verdict_t                    pending [$];
		int unsigned                 mismatches;

		function new();
			rank_long    = rqsg_pkg::RST_RANK_LONG;
			rank_short   = rqsg_pkg::RST_RANK_SHORT;
			long_min     = rqsg_pkg::RST_LONG_MIN;
			short_max    = rqsg_pkg::RST_SHORT_MAX;
			cooldown_len = rqsg_pkg::RST_COOLDOWN;
			warmup_len   = rqsg_pkg::RST_WARMUP;
			wr_ptr       = '0;
			seen         = 0;
			long_wait    = '0;
			short_wait   = '0;
			mismatches   = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void write_reg(int unsigned index, logic [rqsg_pkg::DATA_W-1:0] value);
			case (index)
				int'(rqsg_pkg::REG_RANK_LONG):  rank_long    = value[rqsg_pkg::RANK_W-1:0];
				int'(rqsg_pkg::REG_RANK_SHORT): rank_short   = value[rqsg_pkg::RANK_W-1:0];
				int'(rqsg_pkg::REG_LONG_MIN):   long_min     = value[rqsg_pkg::PROB_W-1:0];
				int'(rqsg_pkg::REG_SHORT_MAX):  short_max    = value[rqsg_pkg::PROB_W-1:0];
				int'(rqsg_pkg::REG_COOLDOWN):   cooldown_len = value[rqsg_pkg::CD_W-1:0];
				int'(rqsg_pkg::REG_WARMUP):     warmup_len   = value[rqsg_pkg::WARM_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted sample: advance the mirror and queue the decision it causes
		function void note_sample(logic [rqsg_pkg::PROB_W-1:0] p);
			int unsigned threshold;
			int unsigned n_le;
			int unsigned n_lt;
			int unsigned kl;
			int unsigned ks;
			verdict_t    v;
			threshold = (warmup_len < rqsg_pkg::WINDOW) ? rqsg_pkg::WINDOW : int'(warmup_len);
			if (long_wait != 0) long_wait--;
			if (short_wait != 0) short_wait--;
			ring[wr_ptr] = p;
			wr_ptr++;
			if (seen < threshold) seen++;
			v.decision = rqsg_pkg::DEC_NEUTRAL;
			v.prob     = rqsg_pkg::NEUTRAL_PROB;
			if (seen >= threshold) begin
				n_le = 0;
				n_lt = 0;
				foreach (ring[i]) begin
					if (ring[i] <= p) n_le++;
					if (ring[i] < p) n_lt++;
				end
				kl = (rank_long > rqsg_pkg::WINDOW - 1) ? rqsg_pkg::WINDOW - 1 : int'(rank_long);
				ks = (rank_short > rqsg_pkg::WINDOW - 1) ? rqsg_pkg::WINDOW - 1 : int'(rank_short);
				if (long_wait == 0 && p >= long_min && n_le > kl) begin
					v.decision = rqsg_pkg::DEC_LONG;
					v.prob     = p;
					long_wait  = cooldown_len;
				end else if (short_wait == 0 && p <= short_max && n_lt <= ks) begin
					v.decision = rqsg_pkg::DEC_SHORT;
					v.prob     = p;
					short_wait = cooldown_len;
				end
			end
			pending.insert(pending.size(), v);
		endfunction

		function void check_result(logic [rqsg_pkg::DEC_W-1:0] dec,
				logic [rqsg_pkg::PROB_W-1:0] prob);
			verdict_t want;
			if (pending.size() == 0) begin
				mismatches++;
				$display("%0t result with none expected: decision %0d prob_out %0d",
					$time, dec, prob);
				return;
			end
			want = pending.pop_front();
			if (dec !== want.decision) begin
				mismatches++;
				$display("%0t decision expected %0d actual %0d",
					$time, want.decision, dec);
			end
			if (prob !== want.prob) begin
				mismatches++;
				$display("%0t prob_out expected %0d actual %0d",
					$time, want.prob, prob);
			end
		endfunction
	endclass

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic [rqsg_pkg::PROB_W-1:0]   probability = '0;
	logic                          out_ready   = 1'b0;
	logic                          psel        = 1'b0;
	logic                          penable     = 1'b0;
	logic                          pwrite      = 1'b0;
	logic [rqsg_pkg::PADDR_W-1:0]  paddr       = '0;
	logic [rqsg_pkg::DATA_W-1:0]   pwdata      = '0;
	wire                           in_ready;
	wire                           out_valid;
	wire [rqsg_pkg::DEC_W-1:0]     decision;
	wire [rqsg_pkg::PROB_W-1:0]    prob_out;
	wire [rqsg_pkg::DATA_W-1:0]    prdata;
	wire                           pready;

	signal_gate_tracker          tracker;
	int unsigned                 cycle_count     = 0;
	int unsigned                 sender_idle_pct = 0;
	int unsigned                 recv_stall_pct  = 0;
	bit                          hold_pending    = 1'b0;
	int unsigned                 hold_left       = 0;
	logic [rqsg_pkg::PROB_W-1:0] last_sample     = '0;
	logic [rqsg_pkg::PROB_W-1:0] preset_samples [$];

	rolling_quantile_signal_gate_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.probability(probability),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.decision   (decision),
		.prob_out   (prob_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off counted here
	always @(posedge clk) begin
		if (hold_pending) begin
			hold_left    = HOLD_CYCLES;
			hold_pending = 1'b0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor, sampled before this edge's updates land
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) tracker.check_result(decision, prob_out);
	end

	// sample mix: full range, around one half, the extremes, near the clamps, repeats
	function automatic logic [rqsg_pkg::PROB_W-1:0] pick_sample();
		int unsigned                 sel;
		logic [rqsg_pkg::PROB_W-1:0] v;
		logic [rqsg_pkg::PROB_W-1:0] base;
		sel = $urandom_range(99);
		if (sel < 35) begin
			v = rqsg_pkg::PROB_W'($urandom);
		end else if (sel < 60) begin
			v = rqsg_pkg::PROB_W'(32768 - 4096 + $urandom_range(8191));
		end else if (sel < 72) begin
			v = $urandom_range(1) ? rqsg_pkg::PROB_W'($urandom_range(15))
				: rqsg_pkg::PROB_W'(65535 - $urandom_range(15));
		end else if (sel < 88) begin
			base = $urandom_range(1) ? tracker.long_min : tracker.short_max;
			v = rqsg_pkg::PROB_W'(int'(base) + int'($urandom_range(64)) - 32);
		end else begin
			// equal values exercise the at-or-below versus strictly-below counts
			v = last_sample;
		end
		last_sample = v;
		return v;
	endfunction

	// apb write: setup cycle, access cycle, then back to idle
	task automatic write_register(input int unsigned index,
			input logic [rqsg_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= rqsg_pkg::PADDR_W'(index * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.write_reg(index, value);
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned rl, input int unsigned rs,
			input int unsigned lm, input int unsigned sm,
			input int unsigned cd, input int unsigned wu);
		write_register(rqsg_pkg::REG_RANK_LONG, rl);
		write_register(rqsg_pkg::REG_RANK_SHORT, rs);
		write_register(rqsg_pkg::REG_LONG_MIN, lm);
		write_register(rqsg_pkg::REG_SHORT_MAX, sm);
		write_register(rqsg_pkg::REG_COOLDOWN, cd);
		write_register(rqsg_pkg::REG_WARMUP, wu);
	endtask

	// offer one item; valid stays up with a fixed payload until accepted
	task automatic send_item(input logic [rqsg_pkg::PROB_W-1:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		probability <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_sample(value);
	endtask

	// preset samples first, then random ones; returns with the gate idle
	task automatic run_batch(input pace_t pace, input int unsigned n_random);
		case (pace)
			PACE_FREE: begin
				sender_idle_pct = 0;
				recv_stall_pct  = 0;
			end
			PACE_SEND_IDLE: begin
				sender_idle_pct = 55;
				recv_stall_pct  = 0;
			end
			PACE_RECV_STALL: begin
				sender_idle_pct = 0;
				recv_stall_pct  = 55;
			end
			default: begin
				sender_idle_pct = 38;
				recv_stall_pct  = 38;
			end
		endcase
		while (preset_samples.size() != 0) send_item(preset_samples.pop_front());
		repeat (n_random) send_item(pick_sample());
		in_valid <= 1'b0;
		// sender pauses until every expected decision has come back
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure_random(input int unsigned phase);
		int unsigned lm;
		int unsigned sm;
		int unsigned cd;
		int unsigned wu;
		int unsigned sel;
		lm = ($urandom_range(99) < 70) ? $urandom_range(38000, 28000) : $urandom_range(65535);
		sm = ($urandom_range(99) < 70) ? $urandom_range(38000, 28000) : $urandom_range(65535);
		sel = $urandom_range(99);
		if (sel < 60) cd = $urandom_range(8, 1);
		else if (sel < 75) cd = 0;
		else if (sel < 85) cd = 255;
		else cd = $urandom_range(255);
		wu = ($urandom_range(99) < 20) ? $urandom_range(300) : 256;
		case (phase)
			// extremes of every register but the warm-up
			0: configure(255, 0, 65535, 0, 255, 256);
			1: configure(0, 0, 0, 0, 1, 256);
			2: configure(255, 255, 65535, 65535, 0, 256);
			default: configure($urandom_range(255), $urandom_range(255), lm, sm, cd, wu);
		endcase
		write_register(REG_SPARE_LO, $urandom);
		write_register(REG_SPARE_HI, $urandom);
	endtask

	initial begin
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill the window at reset settings, decisions expected only once warm-up is reached
		run_batch(PACE_FREE, 260);

		// extremes of the sample and the default clamps, then cooldown runs
		preset_samples = '{16'd0, 16'd65535, 16'd33423, 16'd33422, 16'd32113,
			16'd32114, 16'd32768, 16'd65535, 16'd65535, 16'd65535,
			16'd0, 16'd0, 16'd0, 16'd65535, 16'd1};
		run_batch(PACE_FREE, 0);

		// both sides pass: short gets its turn while long is cooling down
		configure(0, 255, 0, 65535, 3, 256);
		preset_samples = '{16'd100, 16'd100, 16'd65535, 16'd0, 16'd0, 16'd40000};
		run_batch(PACE_SEND_IDLE, 0);

		// zero cooldown fires again on the very next item
		configure(0, 255, 0, 65535, 0, 256);
		preset_samples = '{16'd7, 16'd7, 16'd65535, 16'd0};
		run_batch(PACE_FREE, 0);

		// longest warm-up, then lowered below the window while the count is above it
		configure(rqsg_pkg::RST_RANK_LONG, rqsg_pkg::RST_RANK_SHORT, rqsg_pkg::RST_LONG_MIN,
			rqsg_pkg::RST_SHORT_MAX, rqsg_pkg::RST_COOLDOWN, 65535);
		run_batch(PACE_BOTH, 20);
		write_register(rqsg_pkg::REG_WARMUP, 100);
		run_batch(PACE_RECV_STALL, 40);

		// receiver holds off long enough for the gate to fill and stall its input
		hold_pending = 1'b1;
		run_batch(PACE_FREE, 12);

		for (int unsigned phase = 0; phase < 13; phase++) begin
			configure_random(phase);
			run_batch(pace_t'(phase % 4), 60);
		end

		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
